// ===== hw/rtl/stil_pkg.sv =====
// Shared types and constants for the sorted key table.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package stil_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = CNT_W + 1;   // signed window bounds (hi may reach -1)
    localparam int POS_W    = 6;
    localparam int ENT_W    = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             ok;
        logic [ENT_W-1:0] entries_now;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_HI,
        S_CMP_HI,
        S_RD_LO,
        S_CMP_LO,
        S_RD_MID,
        S_CMP_MID,
        S_LOOP_CHK,
        S_SHIFT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_LK_CHK,
        S_LK_RD,
        S_LK_CMP
    } state_t;

    typedef enum logic [1:0] {
        RD_HI,
        RD_LO,
        RD_MID,
        RD_SHIFT
    } rd_sel_t;

    typedef enum logic [1:0] {
        POS_HI1,
        POS_LO,
        POS_MID
    } pos_src_t;

    typedef struct packed {
        logic     accept;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     lo_to_mid1;
        logic     hi_to_mid;
        logic     hi_to_mid_m1;
        logic     pos_ld;
        pos_src_t pos_src;
        logic     ok_set;
        logic     sp_init;
        logic     sp_dec;
        logic     shift_wr;
        logic     key_wr;
        logic     res_ld;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic full;
        logic empty;
        logic rd_le;      // stored key <= search key
        logic rd_ge;      // stored key >= search key
        logic rd_eq;
        logic rd_gt;      // stored key > search key
        logic lo_gt_hi;
        logic sp_gt_pos;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stil_dp.sv =====
// Datapath: key memory, search window registers, shift pointer and result register.
// Depends on stil_pkg; driven by stil_ctrl through cmd_t, reports through sts_t.
`default_nettype none

module stil_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stil_pkg::req_t req,
    input  wire logic          rsp_stall,
    input  wire stil_pkg::cmd_t cmd,
    output stil_pkg::sts_t     sts,
    output logic               rsp_valid,
    output stil_pkg::rsp_t     rsp
);

    logic [stil_pkg::KEY_BITS-1:0] mem [stil_pkg::CAPACITY];

    logic [stil_pkg::KEY_BITS-1:0]      key_reg;
    logic                               type_reg;
    logic [stil_pkg::KEY_BITS-1:0]      rdata_reg;
    logic [stil_pkg::CNT_W-1:0]         count_reg;
    logic signed [stil_pkg::IDX_W-1:0]  lo_reg;
    logic signed [stil_pkg::IDX_W-1:0]  hi_reg;
    logic [stil_pkg::CNT_W-1:0]         sp_reg;
    logic [stil_pkg::ADDR_W-1:0]        pos_reg;
    logic                               ok_reg;
    logic                               rsp_valid_reg;
    stil_pkg::rsp_t                     rsp_reg;

    logic [stil_pkg::IDX_W-1:0]  sum_w;
    logic [stil_pkg::CNT_W-1:0]  mid_w;
    logic [stil_pkg::IDX_W-1:0]  hi_p1_w;
    logic [stil_pkg::CNT_W-1:0]  sp_m1_w;
    logic [stil_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [stil_pkg::ADDR_W-1:0] wr_addr;
    logic [stil_pkg::KEY_BITS-1:0] wr_data;

    // window bounds are never negative when the midpoint is used
    assign sum_w   = lo_reg + hi_reg;
    assign mid_w   = sum_w[stil_pkg::IDX_W-1:1];
    assign hi_p1_w = hi_reg + stil_pkg::IDX_W'(1);
    assign sp_m1_w = sp_reg - stil_pkg::CNT_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            stil_pkg::RD_HI:    rd_addr = hi_reg[stil_pkg::ADDR_W-1:0];
            stil_pkg::RD_LO:    rd_addr = lo_reg[stil_pkg::ADDR_W-1:0];
            stil_pkg::RD_MID:   rd_addr = mid_w[stil_pkg::ADDR_W-1:0];
            stil_pkg::RD_SHIFT: rd_addr = sp_m1_w[stil_pkg::ADDR_W-1:0];
            default:            rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.shift_wr | cmd.key_wr;
    assign wr_addr = cmd.shift_wr ? sp_reg[stil_pkg::ADDR_W-1:0] : pos_reg;
    assign wr_data = cmd.shift_wr ? rdata_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg  <= req.key[stil_pkg::KEY_BITS-1:0];
            type_reg <= req.req_type;
            lo_reg   <= '0;
            hi_reg   <= $signed(stil_pkg::IDX_W'(count_reg) - stil_pkg::IDX_W'(1));
            pos_reg  <= '0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.lo_to_mid1)
            begin
                lo_reg <= $signed({1'b0, mid_w} + stil_pkg::IDX_W'(1));
            end
            if (cmd.hi_to_mid)
            begin
                hi_reg <= $signed({1'b0, mid_w});
            end
            else if (cmd.hi_to_mid_m1)
            begin
                hi_reg <= $signed({1'b0, mid_w} - stil_pkg::IDX_W'(1));
            end
            if (cmd.pos_ld)
            begin
                case (cmd.pos_src)
                    stil_pkg::POS_HI1: pos_reg <= hi_p1_w[stil_pkg::ADDR_W-1:0];
                    stil_pkg::POS_LO:  pos_reg <= lo_reg[stil_pkg::ADDR_W-1:0];
                    stil_pkg::POS_MID: pos_reg <= mid_w[stil_pkg::ADDR_W-1:0];
                    default:           pos_reg <= '0;
                endcase
            end
            if (cmd.ok_set)
            begin
                ok_reg <= 1'b1;
            end
        end

        if (cmd.sp_init)
        begin
            sp_reg <= count_reg;
        end
        else if (cmd.sp_dec)
        begin
            sp_reg <= sp_m1_w;
        end

        // the key write and the result load share a cycle; fold in its effects
        if (cmd.res_ld)
        begin
            rsp_reg.position    <= stil_pkg::POS_W'(pos_reg);
            rsp_reg.ok          <= ok_reg | cmd.ok_set;
            rsp_reg.entries_now <= stil_pkg::ENT_W'(count_reg + stil_pkg::CNT_W'(cmd.key_wr));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.key_wr)
            begin
                count_reg <= count_reg + stil_pkg::CNT_W'(1);
            end
            if (cmd.res_ld)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.is_lookup = (type_reg == stil_pkg::REQ_LOOKUP);
        sts.full      = (count_reg >= stil_pkg::CNT_W'(stil_pkg::CAPACITY));
        sts.empty     = (count_reg == '0);
        sts.rd_le     = (rdata_reg <= key_reg);
        sts.rd_ge     = (rdata_reg >= key_reg);
        sts.rd_eq     = (rdata_reg == key_reg);
        sts.rd_gt     = (rdata_reg > key_reg);
        sts.lo_gt_hi  = (lo_reg > hi_reg);
        sts.sp_gt_pos = (sp_reg > stil_pkg::CNT_W'(pos_reg));
        sts.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stil_ctrl.sv =====
// Controller: sequences the probe, shift and write steps of one request.
// Depends on stil_pkg; commands stil_dp through cmd_t and reads sts_t back.
`default_nettype none

module stil_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire stil_pkg::sts_t sts,
    output stil_pkg::cmd_t      cmd
);

    stil_pkg::state_t state_reg;
    stil_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stil_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = stil_pkg::RD_HI;
        cmd.pos_src = stil_pkg::POS_LO;
        req_stall  = (state_reg != stil_pkg::S_IDLE);

        case (state_reg)
            stil_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stil_pkg::S_START;
                end
            end
            stil_pkg::S_START:
            begin
                if (sts.is_lookup)
                begin
                    state_next = stil_pkg::S_LK_CHK;
                end
                else if (sts.full)
                begin
                    state_next = stil_pkg::S_WRITE;
                end
                else if (sts.empty)
                begin
                    cmd.pos_ld  = 1'b1;
                    cmd.pos_src = stil_pkg::POS_LO;
                    cmd.sp_init = 1'b1;
                    state_next  = stil_pkg::S_SHIFT_CHK;
                end
                else
                begin
                    state_next = stil_pkg::S_RD_HI;
                end
            end
            stil_pkg::S_RD_HI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stil_pkg::RD_HI;
                state_next = stil_pkg::S_CMP_HI;
            end
            stil_pkg::S_CMP_HI:
            begin
                if (sts.rd_le)
                begin
                    cmd.pos_ld  = 1'b1;
                    cmd.pos_src = stil_pkg::POS_HI1;
                    cmd.sp_init = 1'b1;
                    state_next  = stil_pkg::S_SHIFT_CHK;
                end
                else
                begin
                    state_next = stil_pkg::S_RD_LO;
                end
            end
            stil_pkg::S_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stil_pkg::RD_LO;
                state_next = stil_pkg::S_CMP_LO;
            end
            stil_pkg::S_CMP_LO:
            begin
                if (sts.rd_ge)
                begin
                    cmd.pos_ld  = 1'b1;
                    cmd.pos_src = stil_pkg::POS_LO;
                    cmd.sp_init = 1'b1;
                    state_next  = stil_pkg::S_SHIFT_CHK;
                end
                else
                begin
                    state_next = stil_pkg::S_RD_MID;
                end
            end
            stil_pkg::S_RD_MID:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stil_pkg::RD_MID;
                state_next = stil_pkg::S_CMP_MID;
            end
            stil_pkg::S_CMP_MID:
            begin
                if (sts.rd_le)
                begin
                    cmd.lo_to_mid1 = 1'b1;
                end
                else
                begin
                    cmd.hi_to_mid = 1'b1;
                end
                state_next = stil_pkg::S_LOOP_CHK;
            end
            stil_pkg::S_LOOP_CHK:
            begin
                if (sts.lo_gt_hi)
                begin
                    cmd.pos_ld  = 1'b1;
                    cmd.pos_src = stil_pkg::POS_LO;
                    cmd.sp_init = 1'b1;
                    state_next  = stil_pkg::S_SHIFT_CHK;
                end
                else
                begin
                    state_next = stil_pkg::S_RD_HI;
                end
            end
            // move entries above the slot up by one, top entry first
            stil_pkg::S_SHIFT_CHK:
            begin
                if (sts.sp_gt_pos)
                begin
                    state_next = stil_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = stil_pkg::S_WRITE;
                end
            end
            stil_pkg::S_SHIFT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stil_pkg::RD_SHIFT;
                state_next = stil_pkg::S_SHIFT_WR;
            end
            stil_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.sp_dec   = 1'b1;
                state_next   = stil_pkg::S_SHIFT_CHK;
            end
            // final step of every request: store the key (inserts that fit) and
            // hand the result to the output register once it is free
            stil_pkg::S_WRITE:
            begin
                if (sts.out_free)
                begin
                    if (!sts.is_lookup && !sts.full)
                    begin
                        cmd.key_wr = 1'b1;
                        cmd.ok_set = 1'b1;
                    end
                    cmd.res_ld = 1'b1;
                    state_next = stil_pkg::S_IDLE;
                end
            end
            stil_pkg::S_LK_CHK:
            begin
                if (sts.lo_gt_hi)
                begin
                    state_next = stil_pkg::S_WRITE;
                end
                else
                begin
                    state_next = stil_pkg::S_LK_RD;
                end
            end
            stil_pkg::S_LK_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = stil_pkg::RD_MID;
                state_next = stil_pkg::S_LK_CMP;
            end
            stil_pkg::S_LK_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.pos_ld  = 1'b1;
                    cmd.pos_src = stil_pkg::POS_MID;
                    cmd.ok_set  = 1'b1;
                    state_next  = stil_pkg::S_WRITE;
                end
                else
                begin
                    if (sts.rd_gt)
                    begin
                        cmd.hi_to_mid_m1 = 1'b1;
                    end
                    else
                    begin
                        cmd.lo_to_mid1 = 1'b1;
                    end
                    state_next = stil_pkg::S_LK_CHK;
                end
            end
            default:
            begin
                state_next = stil_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_insert_lookup_core.sv =====
// Top level of the sorted key table: insert with shift-up, binary-search lookup.
// Depends on stil_pkg, stil_ctrl and stil_dp.
//
//   channel | valid     | stall     | payload             | direction
//   --------+-----------+-----------+---------------------+----------
//   request | req_valid | req_stall | req (req_type, key) | in
//   result  | rsp_valid | rsp_stall | rsp (position, ok,  | out
//           |           |           |      entries_now)   |
//
// One request at a time; all keys sit in a single-port-read 64-entry memory.
// Lookup: binary search of at most 7 probes.
// Insert: probe rounds, then each entry above the slot moves up by one; a front
//   insert into a 63-entry table is dominated by the shift.
// Reset clears the entry count and output valid; the key memory needs no clearing.
// A new request beat is taken while the previous result still waits under stall.
`default_nettype none

module sorted_table_insert_lookup_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire stil_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output stil_pkg::rsp_t      rsp
);

    stil_pkg::cmd_t cmd;
    stil_pkg::sts_t sts;

    stil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    stil_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/stil_checker.sv =====
// Port-level checks for the sorted key table, bound to the top level.
// Depends on stil_pkg and sorted_table_insert_lookup_core.
`default_nettype none

module stil_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire stil_pkg::rsp_t rsp
);

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed under stall");

    // one request at a time: the beat after an accept is stalled
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in flight");

    a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.position == '0)
        else $error("position nonzero on a refused or missed request");

    // a found or inserted slot lies inside the table as it stands after the request
    a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ok |-> (stil_pkg::ENT_W'(rsp.position) < rsp.entries_now))
        else $error("position beyond stored entries");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entries_now <= stil_pkg::ENT_W'(stil_pkg::CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind sorted_table_insert_lookup_core stil_checker u_stil_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_table_insert_lookup_core: a shadow key table predicts every result beat.
// Depends on stil_pkg and the core RTL; drives directed requests, then four random phases.

module tb_top;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // Shadow copy of the sorted table plus the queue of results still owed by the core.
    class key_table_model;
        logic [stil_pkg::KEY_BITS-1:0] keys [stil_pkg::CAPACITY];
        int                            count;
        stil_pkg::rsp_t                expected_rsp [$];
        int                            errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Slot search with the core's probe order: last key, first key, then midpoint.
        function int insert_slot(logic [stil_pkg::KEY_BITS-1:0] k);
            int lo;
            int hi;
            int mid;
            if (count == 0)
                return 0;
            lo = 0;
            hi = count - 1;
            for (int g = 0; g <= stil_pkg::CAPACITY + 2; g++)
            begin
                if (keys[hi] <= k)
                    return hi + 1;
                if (keys[lo] >= k)
                    return lo;
                mid = (lo + hi) / 2;
                if (keys[mid] <= k)
                    lo = mid + 1;
                else
                    hi = mid;
                if (lo > hi)
                    return lo;
            end
            return lo;
        endfunction

        // Plain binary search; the first matching probe wins, not the lowest index.
        function bit find_key(logic [stil_pkg::KEY_BITS-1:0] k, output int where);
            int lo;
            int hi;
            int mid;
            lo    = 0;
            hi    = count - 1;
            where = 0;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] == k)
                begin
                    where = mid;
                    return 1'b1;
                end
                if (k < keys[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return 1'b0;
        endfunction

        function void note_request(stil_pkg::req_t r);
            logic [stil_pkg::KEY_BITS-1:0] k;
            int                            slot;
            int                            where;
            stil_pkg::rsp_t                e;
            k = r.key[stil_pkg::KEY_BITS-1:0];
            e = '0;
            if (r.req_type == stil_pkg::REQ_INSERT)
            begin
                if (count < stil_pkg::CAPACITY)
                begin
                    slot = insert_slot(k);
                    if (slot > count)
                        slot = count;
                    for (int i = count; i > slot; i--)
                        keys[i] = keys[i - 1];
                    keys[slot] = k;
                    count++;
                    e.position = stil_pkg::POS_W'(slot);
                    e.ok       = 1'b1;
                end
            end
            else if (find_key(k, where))
            begin
                e.position = stil_pkg::POS_W'(where);
                e.ok       = 1'b1;
            end
            e.entries_now = stil_pkg::ENT_W'(count);
            expected_rsp.push_back(e);
        endfunction

        function void check_rsp(stil_pkg::rsp_t got);
            stil_pkg::rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: pos=%0d ok=%0b entries=%0d",
                             got.position, got.ok, got.entries_now);
                return;
            end
            e = expected_rsp.pop_front();
            if (got.position !== e.position || got.ok !== e.ok ||
                got.entries_now !== e.entries_now)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: exp pos=%0d ok=%0b n=%0d, got pos=%0d ok=%0b n=%0d",
                             e.position, e.ok, e.entries_now,
                             got.position, got.ok, got.entries_now);
            end
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    stil_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    stil_pkg::rsp_t rsp;

    key_table_model kt;
    int             send_idle_pct = 0;
    int             rsp_stall_pct = 0;
    int             hold_request  = 0;
    int             hold_left     = 0;
    int unsigned    cycles        = 0;

    sorted_table_insert_lookup_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: check accepted beats, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                kt.check_rsp(rsp);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_req(input stil_pkg::req_t r);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (!lowered)
            begin
                req_valid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        kt.note_request(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (kt.expected_rsp.size() != 0);
    endtask

    // Mostly stored keys (and near misses) for lookups; small and extreme keys make duplicates.
    function automatic logic [31:0] pick_key(bit for_lookup);
        int unsigned sel;
        int unsigned near;
        logic [31:0] k;
        sel  = $urandom_range(99);
        near = for_lookup ? 65 : 25;
        k    = $urandom;
        if (kt.count > 0 && sel < near)
        begin
            k = kt.keys[$urandom_range(kt.count - 1)];
            case ($urandom_range(7))
                0: k = k + 1;
                1: k = k - 1;
                default: ;
            endcase
        end
        else if (sel < near + 20)
            k = $urandom_range(15);
        else if (sel < near + 28)
            k = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        return k;
    endfunction

    task automatic run_directed();
        send_req('{stil_pkg::REQ_LOOKUP, 32'h0000_0000});   // empty table
        send_req('{stil_pkg::REQ_INSERT, 32'h8000_0000});   // empty insert, slot 0
        send_req('{stil_pkg::REQ_INSERT, 32'hFFFF_FFFF});   // append
        send_req('{stil_pkg::REQ_INSERT, 32'h0000_0000});   // front
        send_req('{stil_pkg::REQ_INSERT, 32'h8000_0000});   // duplicate in the middle
        send_req('{stil_pkg::REQ_INSERT, 32'h5555_5555});
        send_req('{stil_pkg::REQ_INSERT, 32'hAAAA_AAAA});
        send_req('{stil_pkg::REQ_INSERT, 32'h0000_0000});   // duplicate at the front
        send_req('{stil_pkg::REQ_INSERT, 32'hFFFF_FFFF});   // duplicate at the end
        send_req('{stil_pkg::REQ_INSERT, 32'h7FFF_FFFF});
        send_req('{stil_pkg::REQ_LOOKUP, 32'h0000_0000});
        send_req('{stil_pkg::REQ_LOOKUP, 32'hFFFF_FFFF});
        send_req('{stil_pkg::REQ_LOOKUP, 32'h8000_0000});
        send_req('{stil_pkg::REQ_LOOKUP, 32'h5555_5555});
        send_req('{stil_pkg::REQ_LOOKUP, 32'hAAAA_AAAA});
        send_req('{stil_pkg::REQ_LOOKUP, 32'h7FFF_FFFF});
        send_req('{stil_pkg::REQ_LOOKUP, 32'h1234_5678});   // absent
        send_req('{stil_pkg::REQ_LOOKUP, 32'hFFFF_FFFE});   // absent, next to the top key
        send_req('{stil_pkg::REQ_LOOKUP, 32'h0000_0001});   // absent, next to the bottom key
        wait_drained();
    endtask

    // Inserts are rare so the table fills over the first three phases; once full they are refused.
    task automatic run_random(int n_items, int idle_pct, int stall_pct, int hold_at);
        stil_pkg::req_t r;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                hold_request = HOLD_CYCLES;
            r.req_type = ($urandom_range(kt.count < stil_pkg::CAPACITY ? 19 : 24) == 0) ?
                         stil_pkg::REQ_INSERT : stil_pkg::REQ_LOOKUP;
            r.key      = pick_key(r.req_type == stil_pkg::REQ_LOOKUP);
            send_req(r);
        end
        wait_drained();
    endtask

    initial
    begin
        kt = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(400, 0, 0, 50);
        run_random(400, 57, 0, -1);
        run_random(400, 0, 57, -1);
        run_random(400, 18, 18, -1);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (kt.errors == 0 && kt.expected_rsp.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stil_pkg.sv
hw/rtl/stil_dp.sv
hw/rtl/stil_ctrl.sv
hw/rtl/sorted_table_insert_lookup_core.sv
hw/rtl/stil_checker.sv
dv/tb_top.sv
